// ===== hdl/amrf_pkg.sv =====
// ----------------------------------------------------------------------------
// amrf_pkg
// Shared types, codes and constants for the attitude mount rotation block.
// ----------------------------------------------------------------------------
package amrf_pkg;

  // Q2.14 quaternion component and a packed quaternion (index 0 is w)
  typedef logic signed [15:0] amrf_comp_t;
  typedef amrf_comp_t [3:0] amrf_quat_t;

  localparam int unsigned CompW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] MountWReset = 16'd16384;
  localparam logic [15:0] StaleLimitReset = 16'd250;
  localparam amrf_comp_t QOne = 16'sd16384;

  // Hamilton product: term j of component i is q[j] * m[i ^ j]; set bit (4*i + j) negates
  localparam logic [15:0] HamNegMask = 16'h428E;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MOUNT_W = 3'd0,
    CFG_MOUNT_X = 3'd1,
    CFG_MOUNT_Y = 3'd2,
    CFG_MOUNT_Z = 3'd3,
    CFG_STALE   = 3'd4
  } amrf_cfg_idx_t;

  // Upstream record status
  typedef enum logic [2:0] {
    SRC_VALID   = 3'd0,
    SRC_FAULT   = 3'd1,
    SRC_UNAVAIL = 3'd2,
    SRC_NODATA  = 3'd3
  } amrf_src_t;

  // Result status and reason
  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_FAULT   = 2'd1,
    ST_UNAVAIL = 2'd2,
    ST_NODATA  = 2'd3
  } amrf_status_t;

  typedef enum logic [2:0] {
    RS_NONE     = 3'd0,
    RS_MISSING  = 3'd1,
    RS_CHANGED  = 3'd2,
    RS_BAD_QUAT = 3'd3,
    RS_UPSTREAM = 3'd4,
    RS_STALE    = 3'd5
  } amrf_reason_t;

  // Top level control
  typedef enum logic {
    T_IDLE,
    T_BUSY
  } amrf_top_state_t;

  // Rotation unit sequencer
  typedef enum logic [3:0] {
    R_IDLE,
    R_MUL,
    R_MUL_END,
    R_SCALE,
    R_SQ,
    R_SQ_END,
    R_SQRT,
    R_CHECK,
    R_DIV_LOAD,
    R_DIV,
    R_DONE
  } amrf_rot_state_t;

  // Handshake between the top level and the rotation unit
  typedef struct packed {
    logic start;
    logic done;
  } amrf_rot_ctl_t;

endpackage

// ===== hdl/amrf_if.sv =====
// ----------------------------------------------------------------------------
// amrf_in_if / amrf_out_if
// Request channels of the attitude mount rotation block.
// ----------------------------------------------------------------------------
interface amrf_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         source_status;
  logic               has_sample;
  logic               payload_ok;
  logic [31:0]        sample_sequence;
  logic [15:0]        sample_epoch;
  logic [15:0]        upstream_epoch;
  logic [15:0]        payload_epoch;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic [31:0]        now_ms;

  modport source (
    output valid, source_status, has_sample, payload_ok, sample_sequence, sample_epoch,
           upstream_epoch, payload_epoch, quat_w, quat_x, quat_y, quat_z, now_ms,
    input  ready
  );
  modport sink (
    input  valid, source_status, has_sample, payload_ok, sample_sequence, sample_epoch,
           upstream_epoch, payload_epoch, quat_w, quat_x, quat_y, quat_z, now_ms,
    output ready
  );
endinterface

interface amrf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [2:0]         reason;
  logic               published;
  logic signed [15:0] body_w;
  logic signed [15:0] body_x;
  logic signed [15:0] body_y;
  logic signed [15:0] body_z;
  logic [15:0]        body_epoch;
  logic [15:0]        pub_epoch;
  logic [31:0]        pub_sequence;

  modport source (
    output valid, status, reason, published, body_w, body_x, body_y, body_z,
           body_epoch, pub_epoch, pub_sequence,
    input  ready
  );
  modport sink (
    input  valid, status, reason, published, body_w, body_x, body_y, body_z,
           body_epoch, pub_epoch, pub_sequence,
    output ready
  );
endinterface

// ===== hdl/attitude_mount_rotate_freshness.sv =====
// ----------------------------------------------------------------------------
// attitude_mount_rotate_freshness
// Attitude poll tracking with mounting rotation and freshness status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one poll request of the upstream attitude record; out_ch
//   returns one status request per poll. Both use valid/ready, a request
//   moves when both are high. cfg_we/cfg_index/cfg_data write the mounting
//   quaternion (indexes 0..3) and the stale limit (index 4); the user must
//   write them only while idle, which the block does not enforce. A poll
//   that does not publish is answered in the cycle after acceptance. A poll
//   with a new attitude sample runs the rotation unit: 16 multiplies and
//   4 squares on one shared multiplier, a 31-step square root and four
//   15-step divides. One poll is worked on at a time; in_ch.ready is low
//   meanwhile. The result sits in an output register until taken; a stalled
//   receiver holds it, and a new poll is accepted in the cycle it is taken.
//   Reset (rst, synchronous) restores the default mount, the 250 ms limit
//   and clears the sample tracking state.
// ----------------------------------------------------------------------------
module attitude_mount_rotate_freshness (
  input  logic                              clk,
  input  logic                              rst,
  amrf_in_if.sink                           in_ch,
  amrf_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [amrf_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [amrf_pkg::CfgDataW-1:0]     cfg_data
);

  amrf_pkg::amrf_top_state_t state, state_next;
  amrf_pkg::amrf_rot_ctl_t   rot_in, rot_out;

  amrf_pkg::amrf_quat_t mount;
  logic [15:0]          stale_limit_ms;
  logic [31:0]          seen_sequence;
  logic [15:0]          seen_epoch;
  logic                 got_new;
  logic                 bad_attitude;
  logic [31:0]          new_time_ms;

  amrf_pkg::amrf_quat_t quat_in, body_q;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [2:0]           out_reason;
  logic                 out_pub;
  amrf_pkg::amrf_quat_t out_body;
  logic [15:0]          out_body_epoch, out_pub_epoch;
  logic [31:0]          out_sequence;
  logic [15:0]          hold_body_epoch, hold_pub_epoch;
  logic [31:0]          hold_sequence;

  logic                 accept;
  logic                 is_new, is_zero, go_rotate, take_sample;
  logic [31:0]          age;
  logic [1:0]           dec_status;
  logic [2:0]           dec_reason;

  assign accept  = in_ch.valid && in_ch.ready;
  assign quat_in = {in_ch.quat_z, in_ch.quat_y, in_ch.quat_x, in_ch.quat_w};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mount          <= {16'sd0, 16'sd0, 16'sd0, amrf_pkg::MountWReset};
      stale_limit_ms <= amrf_pkg::StaleLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        amrf_pkg::CFG_MOUNT_W: mount[0] <= cfg_data;
        amrf_pkg::CFG_MOUNT_X: mount[1] <= cfg_data;
        amrf_pkg::CFG_MOUNT_Y: mount[2] <= cfg_data;
        amrf_pkg::CFG_MOUNT_Z: mount[3] <= cfg_data;
        amrf_pkg::CFG_STALE:   stale_limit_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // poll decision
  always_comb begin
    is_new      = in_ch.has_sample &&
                  ((in_ch.sample_sequence != seen_sequence) ||
                   (in_ch.sample_epoch != seen_epoch));
    is_zero     = (quat_in == '0);
    age         = in_ch.now_ms - new_time_ms;
    take_sample = 1'b0;
    go_rotate   = 1'b0;
    dec_status  = amrf_pkg::ST_VALID;
    dec_reason  = amrf_pkg::RS_NONE;
    if (in_ch.source_status[2]) begin
      dec_status = amrf_pkg::ST_FAULT;
      dec_reason = amrf_pkg::RS_MISSING;
    end else if (is_new) begin
      if (!in_ch.payload_ok) begin
        dec_status = amrf_pkg::ST_FAULT;
        dec_reason = amrf_pkg::RS_CHANGED;
      end else begin
        take_sample = 1'b1;
        if (is_zero) begin
          dec_status = amrf_pkg::ST_FAULT;
          dec_reason = amrf_pkg::RS_BAD_QUAT;
        end else begin
          go_rotate = 1'b1;
        end
      end
    end else if (in_ch.source_status == amrf_pkg::SRC_FAULT ||
                 in_ch.source_status == amrf_pkg::SRC_UNAVAIL) begin
      dec_status = in_ch.source_status[1:0];
      dec_reason = amrf_pkg::RS_UPSTREAM;
    end else if (!in_ch.has_sample) begin
      dec_status = amrf_pkg::ST_NODATA;
    end else if (bad_attitude) begin
      dec_status = amrf_pkg::ST_FAULT;
      dec_reason = amrf_pkg::RS_BAD_QUAT;
    end else if (stale_limit_ms != '0 && got_new && age > 32'(stale_limit_ms)) begin
      dec_status = amrf_pkg::ST_UNAVAIL;
      dec_reason = amrf_pkg::RS_STALE;
    end
  end

  // sample tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_sequence <= '0;
      seen_epoch    <= '0;
      got_new       <= 1'b0;
      bad_attitude  <= 1'b0;
      new_time_ms   <= '0;
    end else if (accept && take_sample) begin
      seen_sequence <= in_ch.sample_sequence;
      seen_epoch    <= in_ch.sample_epoch;
      got_new       <= 1'b1;
      new_time_ms   <= in_ch.now_ms;
      bad_attitude  <= is_zero;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amrf_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    rot_in.start = 1'b0;
    rot_in.done  = 1'b0;
    unique case (state)
      amrf_pkg::T_IDLE: begin
        if (accept && go_rotate) begin
          rot_in.start = 1'b1;
          state_next   = amrf_pkg::T_BUSY;
        end
      end
      amrf_pkg::T_BUSY: if (rot_out.done) state_next = amrf_pkg::T_IDLE;
      default: state_next = amrf_pkg::T_IDLE;
    endcase
  end

  assign in_ch.ready = (state == amrf_pkg::T_IDLE) && (!out_valid || out_ch.ready);

  amrf_rot u_rot (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (rot_in),
    .ctl_out (rot_out),
    .quat    (quat_in),
    .mount   (mount),
    .body    (body_q)
  );

  // epochs and sequence held while the rotation runs
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_body_epoch <= in_ch.payload_epoch + in_ch.upstream_epoch;
      hold_pub_epoch  <= in_ch.sample_epoch + in_ch.upstream_epoch;
      hold_sequence   <= in_ch.sample_sequence;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && !go_rotate) begin
      out_valid <= 1'b1;
    end else if (state == amrf_pkg::T_BUSY && rot_out.done) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end

    if (accept && !go_rotate) begin
      out_status     <= dec_status;
      out_reason     <= dec_reason;
      out_pub        <= 1'b0;
      out_body       <= '0;
      out_body_epoch <= '0;
      out_pub_epoch  <= '0;
      out_sequence   <= '0;
    end else if (state == amrf_pkg::T_BUSY && rot_out.done) begin
      out_status     <= amrf_pkg::ST_VALID;
      out_reason     <= amrf_pkg::RS_NONE;
      out_pub        <= 1'b1;
      out_body       <= body_q;
      out_body_epoch <= hold_body_epoch;
      out_pub_epoch  <= hold_pub_epoch;
      out_sequence   <= hold_sequence;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.reason       = out_reason;
  assign out_ch.published    = out_pub;
  assign out_ch.body_w       = out_body[0];
  assign out_ch.body_x       = out_body[1];
  assign out_ch.body_y       = out_body[2];
  assign out_ch.body_z       = out_body[3];
  assign out_ch.body_epoch   = out_body_epoch;
  assign out_ch.pub_epoch    = out_pub_epoch;
  assign out_ch.pub_sequence = out_sequence;

  // checks
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    state == amrf_pkg::T_BUSY |-> !in_ch.ready) else $error("poll taken while rotating");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    rot_out.done |-> state == amrf_pkg::T_BUSY) else $error("rotation done while idle");
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    rot_out.done |-> !out_valid) else $error("rotation result would overwrite pending result");
  a_pub_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pub |-> out_status == amrf_pkg::ST_VALID) else $error("published with fault");

endmodule

// ===== hdl/amrf_rot.sv =====
// ----------------------------------------------------------------------------
// amrf_rot
// Iterative Hamilton product and normalisation on one shared multiplier,
// a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module amrf_rot (
  input  logic                clk,
  input  logic                rst,
  input  amrf_pkg::amrf_rot_ctl_t ctl_in,
  output amrf_pkg::amrf_rot_ctl_t ctl_out,
  input  amrf_pkg::amrf_quat_t quat,
  input  amrf_pkg::amrf_quat_t mount,
  output amrf_pkg::amrf_quat_t body
);

  amrf_pkg::amrf_rot_state_t st, st_next;

  logic [4:0]         cnt;
  amrf_pkg::amrf_quat_t qv, mv;
  logic signed [33:0] acc [4];
  logic [29:0]        mag [4];
  logic               neg [4];
  logic [61:0]        n2;
  logic [30:0]        root;
  logic [33:0]        srem;
  logic [31:0]        drem;
  logic [14:0]        nb;
  logic [14:0]        quo;
  logic [1:0]         ci;
  logic signed [61:0] prod;
  logic               prod_vld;
  logic               prod_sq;
  logic [3:0]         prod_tag;

  logic signed [30:0] mul_a, mul_b;
  logic [32:0]        amag [4];
  logic [32:0]        mag_or;
  logic [1:0]         sh;
  logic [33:0]        remt, trial;
  logic               sq_ge;
  logic [45:0]        numer;
  logic [32:0]        rem2, dv;
  logic               div_ge;
  logic [14:0]        qn;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= amrf_pkg::R_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // sequencer
  always_comb begin
    st_next = st;
    unique case (st)
      amrf_pkg::R_IDLE:     if (ctl_in.start) st_next = amrf_pkg::R_MUL;
      amrf_pkg::R_MUL:      if (cnt == 5'd15) st_next = amrf_pkg::R_MUL_END;
      amrf_pkg::R_MUL_END:  st_next = amrf_pkg::R_SCALE;
      amrf_pkg::R_SCALE:    st_next = amrf_pkg::R_SQ;
      amrf_pkg::R_SQ:       if (cnt == 5'd3) st_next = amrf_pkg::R_SQ_END;
      amrf_pkg::R_SQ_END:   st_next = amrf_pkg::R_SQRT;
      amrf_pkg::R_SQRT:     if (cnt == 5'd30) st_next = amrf_pkg::R_CHECK;
      amrf_pkg::R_CHECK:    st_next = (root == '0) ? amrf_pkg::R_DONE : amrf_pkg::R_DIV_LOAD;
      amrf_pkg::R_DIV_LOAD: st_next = amrf_pkg::R_DIV;
      amrf_pkg::R_DIV: begin
        if (cnt == 5'd14) st_next = (ci == 2'd3) ? amrf_pkg::R_DONE : amrf_pkg::R_DIV_LOAD;
      end
      amrf_pkg::R_DONE:     st_next = amrf_pkg::R_IDLE;
      default:              st_next = amrf_pkg::R_IDLE;
    endcase
  end

  assign ctl_out.start = 1'b0;
  assign ctl_out.done  = (st == amrf_pkg::R_DONE);

  // shared multiplier operands: product terms, then squares
  always_comb begin
    if (st == amrf_pkg::R_MUL) begin
      mul_a = 31'(qv[cnt[1:0]]);
      mul_b = 31'(mv[cnt[3:2] ^ cnt[1:0]]);
    end else begin
      mul_a = {1'b0, mag[cnt[1:0]]};
      mul_b = {1'b0, mag[cnt[1:0]]};
    end
  end

  // magnitudes and the scaling shift
  always_comb begin
    mag_or = '0;
    for (int i = 0; i < 4; i++) begin
      amag[i] = acc[i][33] ? 33'(-acc[i]) : acc[i][32:0];
      mag_or  = mag_or | amag[i];
    end
    if (mag_or[32])      sh = 2'd3;
    else if (mag_or[31]) sh = 2'd2;
    else if (mag_or[30]) sh = 2'd1;
    else                 sh = 2'd0;
  end

  // square root step, two radicand bits per cycle
  assign remt  = {srem[31:0], n2[61:60]};
  assign trial = {1'b0, root, 2'b01};
  assign sq_ge = (remt >= trial);

  // division step: (mag * 2^15 + n) / (2n), one quotient bit per cycle
  assign numer  = {1'b0, mag[ci], 15'd0} + 46'(root);
  assign rem2   = {drem, nb[14]};
  assign dv     = {1'b0, root, 1'b0};
  assign div_ge = (rem2 >= dv);
  assign qn     = {quo[13:0], div_ge};

  // product pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (st == amrf_pkg::R_MUL) || (st == amrf_pkg::R_SQ);
    end
    prod     <= mul_a * mul_b;
    prod_sq  <= (st == amrf_pkg::R_SQ);
    prod_tag <= cnt[3:0];
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt <= (st_next != st) ? 5'd0 : cnt + 5'd1;

    // accumulate the registered product
    if (prod_vld) begin
      if (prod_sq) begin
        n2 <= n2 + prod;
      end else if (amrf_pkg::HamNegMask[prod_tag]) begin
        acc[prod_tag[3:2]] <= acc[prod_tag[3:2]] - prod[33:0];
      end else begin
        acc[prod_tag[3:2]] <= acc[prod_tag[3:2]] + prod[33:0];
      end
    end

    case (st)
      amrf_pkg::R_IDLE: begin
        if (ctl_in.start) begin
          qv <= quat;
          mv <= mount;
          for (int i = 0; i < 4; i++) acc[i] <= '0;
        end
      end
      amrf_pkg::R_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          mag[i] <= 30'(amag[i] >> sh);
          neg[i] <= acc[i][33];
        end
        n2   <= '0;
        root <= '0;
        srem <= '0;
      end
      amrf_pkg::R_SQRT: begin
        n2 <= {n2[59:0], 2'b00};
        if (sq_ge) begin
          srem <= remt - trial;
          root <= {root[29:0], 1'b1};
        end else begin
          srem <= remt;
          root <= {root[29:0], 1'b0};
        end
      end
      amrf_pkg::R_CHECK: begin
        ci <= 2'd0;
        if (root == '0) body <= {16'sd0, 16'sd0, 16'sd0, amrf_pkg::QOne};
      end
      amrf_pkg::R_DIV_LOAD: begin
        drem <= {1'b0, numer[45:15]};
        nb   <= numer[14:0];
        quo  <= '0;
      end
      amrf_pkg::R_DIV: begin
        drem <= div_ge ? 32'(rem2 - dv) : rem2[31:0];
        nb   <= {nb[13:0], 1'b0};
        quo  <= qn;
        if (cnt == 5'd14) begin
          body[ci] <= neg[ci] ? 16'(-{1'b0, qn}) : {1'b0, qn};
          ci       <= ci + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl_in.start |-> st == amrf_pkg::R_IDLE) else $error("start while rotation busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    ctl_out.done |=> st == amrf_pkg::R_IDLE) else $error("rotation did not return to idle");
  a_sqrt_cnt: assert property (@(posedge clk) disable iff (rst)
    st == amrf_pkg::R_SQRT |-> cnt <= 5'd30) else $error("square root ran too long");
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    st == amrf_pkg::R_DIV |-> cnt <= 5'd14) else $error("divider ran too long");

endmodule
